FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Next-cycle implication built on the clocked form.
`define ASSERT_NEXT(label, pre, post, msg) \
  `ASSERT_CLK(label, (pre) |=> (post), msg)

`endif

FILE: sv/ctcgd_pkg.sv
// ----------------------------------------------------------------------------
// ctcgd_pkg
// Widths, limits and register indexes of the CTC greedy decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ctcgd_pkg;

  localparam int unsigned MAX_CLASSES = 8192;
  localparam int unsigned MAX_STEPS   = 256;

  localparam int unsigned SCORE_W = 16;
  localparam int unsigned CLS_W   = 13;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned SUM_W   = 24;
  localparam int unsigned AVG_W   = 16;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;

  localparam int unsigned DIV_STEPS = SUM_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CLS_W-1:0] CLASS_LAST = CLS_W'(MAX_CLASSES - 1);
  localparam logic [CNT_W-1:0] COUNT_MAX  = CNT_W'(MAX_STEPS);
  localparam logic [SUM_W-1:0] SUM_MAX    = {SUM_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REMOVE_DUP = 1'b0,
    CFG_BLANK      = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    KIND_SYMBOL  = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

endpackage

`default_nettype wire

FILE: sv/ctc_greedy_decoder.sv
// Timing: a symbol request is registered and appears at the output in the
//   cycle after the score that ends its time step; the summary is computed
//   in S_DIV and loaded from S_SUM once the output register is free.
// Throughput: one score per cycle within a sequence unless the output stalls;
//   a sequence end blocks input through the one-bit-a-cycle restoring divider.
// Reset: asynchronous, active low; remove_duplicates=1, blank_class=0, all
//   decoder state zero, output empty. No clearing pass.
// ----------------------------------------------------------------------------
// ctc_greedy_decoder
// Streaming argmax per time step with blank and duplicate removal, plus a
// per-sequence summary of symbol count and mean symbol score.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ctc_greedy_decoder
  import ctcgd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // score stream
  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] score
  input  wire logic                  s_axis_tuser,   // [0] end_of_step
  input  wire logic                  s_axis_tlast,   // end_of_sequence
  // result stream
  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [12:0] class_index, [28:13] symbol_score, [44:29] average_confidence,
  // [53:45] symbol_count, [55:54] zero
  output      logic [OUT_DATA_W-1:0] m_axis_tdata,
  output      logic                  m_axis_tuser,   // [0] kind
  output      logic                  m_axis_tlast    // last
);

  typedef enum logic [1:0] {
    S_RUN,  // take scores
    S_DIV,  // divide score sum by symbol count
    S_SUM   // load summary once the output register frees up
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic             rm_dup_q, rm_dup_d;
  logic [CLS_W-1:0] blank_q, blank_d;

  // decoder state
  logic [SCORE_W-1:0] best_score_q, best_score_d;
  logic [CLS_W-1:0]   best_class_q, best_class_d;
  logic [CLS_W-1:0]   class_cnt_q, class_cnt_d;
  logic [CLS_W-1:0]   prev_argmax_q, prev_argmax_d;
  logic               prev_valid_q, prev_valid_d;
  logic [SUM_W-1:0]   score_sum_q, score_sum_d;
  logic [CNT_W-1:0]   emit_cnt_q, emit_cnt_d;

  // restoring divider: quotient shifts in as the dividend shifts out
  logic [SUM_W-1:0]     quo_q, quo_d;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;

  // output register
  logic               out_valid_q, out_valid_d;
  kind_e              out_kind_q, out_kind_d;
  logic [CLS_W-1:0]   out_cls_q, out_cls_d;
  logic [SCORE_W-1:0] out_score_q, out_score_d;
  logic [AVG_W-1:0]   out_avg_q, out_avg_d;
  logic [CNT_W-1:0]   out_cnt_q, out_cnt_d;

  logic               out_free;
  logic               accept;
  logic               eos;
  logic               eostep;
  logic               take;
  logic [SCORE_W-1:0] step_score;
  logic [CLS_W-1:0]   step_class;
  logic               drop;
  logic [SUM_W:0]     sum_add;
  logic [SUM_W-1:0]   sum_next;
  logic [CNT_W:0]     trial;
  logic [CNT_W:0]     diff;
  logic               trial_ge;
  logic [AVG_W-1:0]   avg;

  // The output register frees up in the same cycle it is taken, so a new
  // request can follow a waiting result without a bubble.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_RUN) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign eos           = s_axis_tlast;
  assign eostep        = s_axis_tuser || s_axis_tlast;

  // Running argmax: the first score of a step always wins, later ones only
  // when strictly larger, which keeps the first maximum on ties.
  assign take       = (class_cnt_q == '0) || (s_axis_tdata > best_score_q);
  assign step_score = take ? s_axis_tdata : best_score_q;
  assign step_class = take ? class_cnt_q : best_class_q;

  assign drop = (step_class == blank_q) ||
                (rm_dup_q && prev_valid_q && (step_class == prev_argmax_q));

  assign sum_add  = {1'b0, score_sum_q} + {{(SUM_W+1-SCORE_W){1'b0}}, step_score};
  assign sum_next = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];

  // One restoring-division step per cycle.
  assign trial    = {rem_q, quo_q[SUM_W-1]};
  assign trial_ge = trial >= {1'b0, emit_cnt_q};
  assign diff     = trial - {1'b0, emit_cnt_q};

  // Clamp the quotient to the score range; no symbols means a zero mean.
  always_comb begin
    if (emit_cnt_q == '0) begin
      avg = '0;
    end else if (|quo_q[SUM_W-1:AVG_W]) begin
      avg = {AVG_W{1'b1}};
    end else begin
      avg = quo_q[AVG_W-1:0];
    end
  end

  always_comb begin
    state_d       = state_q;
    rm_dup_d      = rm_dup_q;
    blank_d       = blank_q;
    best_score_d  = best_score_q;
    best_class_d  = best_class_q;
    class_cnt_d   = class_cnt_q;
    prev_argmax_d = prev_argmax_q;
    prev_valid_d  = prev_valid_q;
    score_sum_d   = score_sum_q;
    emit_cnt_d    = emit_cnt_q;
    quo_d         = quo_q;
    rem_d         = rem_q;
    div_cnt_d     = div_cnt_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_kind_d    = out_kind_q;
    out_cls_d     = out_cls_q;
    out_score_d   = out_score_q;
    out_avg_d     = out_avg_q;
    out_cnt_d     = out_cnt_q;

    // The user must write registers only while idle; the block does not
    // enforce it. Unknown indexes cannot occur with a one-bit index.
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_REMOVE_DUP: rm_dup_d = cfg_data_i[0];
        CFG_BLANK:      blank_d  = cfg_data_i[CLS_W-1:0];
        default:        ;
      endcase
    end

    unique case (state_q)
      S_RUN: begin
        if (accept) begin
          if (eostep) begin
            // Decide the step, then restart the argmax for the next one.
            if (!drop) begin
              out_valid_d = 1'b1;
              out_kind_d  = KIND_SYMBOL;
              out_cls_d   = step_class;
              out_score_d = step_score;
              out_avg_d   = '0;
              out_cnt_d   = '0;
              if (emit_cnt_q < COUNT_MAX) begin
                emit_cnt_d  = emit_cnt_q + 1'b1;
                score_sum_d = sum_next;
              end
            end
            prev_argmax_d = step_class;
            prev_valid_d  = 1'b1;
            best_score_d  = '0;
            best_class_d  = '0;
            class_cnt_d   = '0;
          end else begin
            best_score_d = step_score;
            best_class_d = step_class;
            if (class_cnt_q != CLASS_LAST) begin
              class_cnt_d = class_cnt_q + 1'b1;
            end
          end
          if (eos) begin
            // Start the divider on the sum including this step's symbol.
            quo_d     = score_sum_d;
            rem_d     = '0;
            div_cnt_d = '0;
            state_d   = S_DIV;
          end
        end
      end
      S_DIV: begin
        quo_d     = {quo_q[SUM_W-2:0], trial_ge};
        rem_d     = trial_ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        // Hold until a pending symbol leaves, then emit and clear.
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_kind_d    = KIND_SUMMARY;
          out_cls_d     = '0;
          out_score_d   = '0;
          out_avg_d     = avg;
          out_cnt_d     = emit_cnt_q;
          best_score_d  = '0;
          best_class_d  = '0;
          class_cnt_d   = '0;
          prev_argmax_d = '0;
          prev_valid_d  = 1'b0;
          score_sum_d   = '0;
          emit_cnt_d    = '0;
          state_d       = S_RUN;
        end
      end
      default: state_d = S_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_RUN;
      rm_dup_q      <= 1'b1;
      blank_q       <= '0;
      best_score_q  <= '0;
      best_class_q  <= '0;
      class_cnt_q   <= '0;
      prev_argmax_q <= '0;
      prev_valid_q  <= 1'b0;
      score_sum_q   <= '0;
      emit_cnt_q    <= '0;
      quo_q         <= '0;
      rem_q         <= '0;
      div_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
      out_kind_q    <= KIND_SYMBOL;
      out_cls_q     <= '0;
      out_score_q   <= '0;
      out_avg_q     <= '0;
      out_cnt_q     <= '0;
    end else begin
      state_q       <= state_d;
      rm_dup_q      <= rm_dup_d;
      blank_q       <= blank_d;
      best_score_q  <= best_score_d;
      best_class_q  <= best_class_d;
      class_cnt_q   <= class_cnt_d;
      prev_argmax_q <= prev_argmax_d;
      prev_valid_q  <= prev_valid_d;
      score_sum_q   <= score_sum_d;
      emit_cnt_q    <= emit_cnt_d;
      quo_q         <= quo_d;
      rem_q         <= rem_d;
      div_cnt_q     <= div_cnt_d;
      out_valid_q   <= out_valid_d;
      out_kind_q    <= out_kind_d;
      out_cls_q     <= out_cls_d;
      out_score_q   <= out_score_d;
      out_avg_q     <= out_avg_d;
      out_cnt_q     <= out_cnt_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = (out_kind_q == KIND_SUMMARY);
  assign m_axis_tdata  = {{(OUT_DATA_W-CLS_W-SCORE_W-AVG_W-CNT_W){1'b0}},
                          out_cnt_q, out_avg_q, out_score_q, out_cls_q};

  // A sequence end always starts the divider.
  `ASSERT_NEXT(a_eos_starts_div, accept && eos, state_q == S_DIV,
               "sequence end did not start the divider")
  // The symbol count never passes its limit.
  `ASSERT_CLK(a_count_limit, emit_cnt_q <= COUNT_MAX,
              "symbol count above limit")
  // The summary leaves the decoder cleared and ready for a new sequence.
  `ASSERT_NEXT(a_sum_clears, (state_q == S_SUM) && out_free,
               (state_q == S_RUN) && (emit_cnt_q == '0) && !prev_valid_q,
               "summary did not clear the decoder state")

endmodule

`default_nettype wire

FILE: verif/ctc_greedy_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ctc_greedy_decoder_tb
// Drives score streams into the CTC greedy decoder and checks every symbol
// and summary request against an in-bench decoder model. It covers tie
// breaking, blank and repeat dropping, symbol-count saturation, and random
// sequences under four input/output pacing modes.
// ----------------------------------------------------------------------------

module ctc_greedy_decoder_tb;
  import ctcgd_pkg::*;

  // Quiet cycles (nothing accepted on either side) before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;
  // Cycles to let the summary divider settle before a register write or the end.
  localparam int SETTLE_CYCLES = 40;

  // One decoder output request, unpacked into its fields.
  typedef struct packed {
    kind_e            kind;
    logic [CLS_W-1:0] class_index;
    logic [15:0]      symbol_score;
    logic [15:0]      average_confidence;
    logic [8:0]       symbol_count;
    logic             seq_end;
  } decoded_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [15:0] score
  logic                  s_axis_tuser = 1'b0; // [0] end_of_step
  logic                  s_axis_tlast = 1'b0; // end_of_sequence
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [12:0] class_index, [28:13] symbol_score, [44:29] average_confidence,
  // [53:45] symbol_count, [55:54] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;        // [0] kind
  logic                  m_axis_tlast;        // last

  ctc_greedy_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Pacing knobs, in percent of cycles.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Register shadow of the decoder.
  bit               drop_repeats = 1'b1;
  logic [CLS_W-1:0] blank_idx    = '0;

  // Decoder model state.
  logic [15:0]      top_score    = '0;
  logic [CLS_W-1:0] top_class    = '0;
  logic [CLS_W-1:0] class_pos    = '0;
  logic [CLS_W-1:0] prior_class  = '0;
  bit               prior_seen   = 1'b0;
  logic [SUM_W-1:0] conf_sum     = '0;
  logic [CNT_W-1:0] symbol_total = '0;

  // Requests the decoder still owes us, oldest first.
  decoded_t decoded_q[$];

  int mismatches    = 0;
  int scores_sent   = 0;
  int seqs_sent     = 0;
  int symbols_seen  = 0;
  int summaries_seen = 0;
  int quiet_cycles  = 0;

  // Advance the decoder model by one score and queue the requests it causes.
  function automatic void decode_score(input logic [15:0] score, input bit step_end,
                                       input bit seq_end);
    decoded_t         res;
    logic [SUM_W:0]   wide_sum;
    logic [CLS_W-1:0] winner;
    int unsigned      mean;
    // A sequence end closes the open step as well.
    if (class_pos == 0 || score > top_score) begin
      top_score = score;
      top_class = class_pos;
    end
    // Past the last index, extra scores keep competing as the last class.
    if (class_pos != CLASS_LAST) class_pos++;
    if (step_end || seq_end) begin
      winner = top_class;
      if (!(winner == blank_idx || (drop_repeats && prior_seen && winner == prior_class))) begin
        res = '0;
        res.kind = KIND_SYMBOL;
        res.class_index = winner;
        res.symbol_score = top_score;
        decoded_q = {decoded_q, res};
        // Past the symbol limit, still emit but stop counting and summing.
        if (symbol_total < COUNT_MAX) begin
          symbol_total++;
          wide_sum = conf_sum + top_score;
          conf_sum = (wide_sum > SUM_MAX) ? SUM_MAX : wide_sum[SUM_W-1:0];
        end
      end
      prior_class = winner;
      prior_seen = 1'b1;
      top_score = '0;
      top_class = '0;
      class_pos = '0;
    end
    if (seq_end) begin
      mean = (symbol_total != 0) ? conf_sum / symbol_total : 0;
      if (mean > 32'hFFFF) mean = 32'hFFFF;
      res = '0;
      res.kind = KIND_SUMMARY;
      res.average_confidence = mean[15:0];
      res.symbol_count = symbol_total;
      res.seq_end = 1'b1;
      decoded_q = {decoded_q, res};
      top_score = '0;
      top_class = '0;
      class_pos = '0;
      prior_class = '0;
      prior_seen = 1'b0;
      conf_sum = '0;
      symbol_total = '0;
    end
  endfunction

  // Send one score request; returns right after the edge that accepted it.
  // Leaves tvalid high so back-to-back requests need no extra edge.
  task automatic send_score(input logic [15:0] score, input bit step_end, input bit seq_end);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= IN_DATA_W'($urandom);
      @(posedge clk_i);
    end
    decode_score(score, step_end, seq_end);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= score;
    s_axis_tuser  <= step_end;
    s_axis_tlast  <= seq_end;
    do @(posedge clk_i); while (!s_axis_tready);
    scores_sent++;
    if (seq_end) seqs_sent++;
  endtask

  // Drop tvalid, wait out every owed request, then let the divider settle.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register; only called while the decoder is idle.
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_REMOVE_DUP: drop_repeats = value[0];
      CFG_BLANK:      blank_idx = value;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hand-picked cases at reset settings, then with repeats kept and a high blank.
  task automatic test_directed;
    // First maximum wins a tie: class 1 with full score.
    send_score(16'd100, 1'b0, 1'b0);
    send_score(16'hFFFF, 1'b0, 1'b0);
    send_score(16'hFFFF, 1'b1, 1'b0);
    // All-zero step picks class 0, which is blank: drop.
    send_score(16'h0000, 1'b0, 1'b0);
    send_score(16'h0000, 1'b1, 1'b0);
    // Class 1 again, but the prior step was blank: emit.
    send_score(16'd5, 1'b0, 1'b0);
    send_score(16'hFFFF, 1'b0, 1'b0);
    send_score(16'd7, 1'b1, 1'b0);
    // Class 1 right after class 1: drop as a repeat.
    send_score(16'd1, 1'b0, 1'b0);
    send_score(16'hFFFF, 1'b1, 1'b0);
    // Sequence end without a step end closes the step first.
    send_score(16'd9, 1'b0, 1'b0);
    send_score(16'd3, 1'b0, 1'b1);
    // A sequence that emits nothing: zero count and zero mean.
    send_score(16'h0000, 1'b0, 1'b1);
    drain();
    write_reg(CFG_REMOVE_DUP, '0);
    write_reg(CFG_BLANK, CLASS_LAST);
    // With repeats kept, the same class is emitted twice in a row.
    send_score(16'h0000, 1'b0, 1'b0);
    send_score(16'hFFFF, 1'b1, 1'b0);
    send_score(16'h0000, 1'b0, 1'b0);
    send_score(16'hFFFF, 1'b1, 1'b0);
    // Step end and sequence end on one score: symbol then summary.
    send_score(16'd8000, 1'b1, 1'b1);
    drain();
  endtask

  // More emitting steps than the symbol count limit, with high scores so the
  // running sum comes close to its ceiling.
  task automatic test_symbol_limit;
    int stepn;
    write_reg(CFG_REMOVE_DUP, '0);
    write_reg(CFG_BLANK, CLASS_LAST);
    for (stepn = 0; stepn < MAX_STEPS + 40; stepn++) begin
      send_score(16'($urandom_range(65535, 60000)), 1'b0, 1'b0);
      send_score(16'($urandom_range(65535, 60000)), 1'b1, stepn == MAX_STEPS + 39);
    end
    drain();
  endtask

  // Random well-formed sequences with a fresh setting, under one pacing mode.
  task automatic test_random(input int idle_pct, input int stall_pct, input int n_scores);
    int          sent;
    int          n_steps;
    int          n_cls;
    int          s;
    int          c;
    logic [15:0] tie;
    logic [15:0] score;
    bit          step_end;
    bit          seq_end;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    write_reg(CFG_REMOVE_DUP, CFG_DATA_W'($urandom));
    case ($urandom_range(3))
      0: write_reg(CFG_BLANK, CFG_DATA_W'($urandom_range(5)));
      1: write_reg(CFG_BLANK, CLASS_LAST);
      2: write_reg(CFG_BLANK, CFG_DATA_W'($urandom));
      default: write_reg(CFG_BLANK, '0);
    endcase
    sent = 0;
    while (sent < n_scores) begin
      n_steps = $urandom_range(8, 1);
      for (s = 0; s < n_steps; s++) begin
        n_cls = $urandom_range(6, 1);
        tie = 16'($urandom);
        for (c = 0; c < n_cls; c++) begin
          // Favor shared values so ties and extremes turn up often.
          case ($urandom_range(9))
            0:       score = 16'h0000;
            1:       score = 16'hFFFF;
            2, 3:    score = tie;
            default: score = 16'($urandom);
          endcase
          // Mostly clean step boundaries, with some merged or split steps.
          step_end = (c == n_cls - 1) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
          seq_end = (s == n_steps - 1) && (c == n_cls - 1);
          if (seq_end) step_end = 1'($urandom_range(1));
          send_score(score, step_end, seq_end);
          sent++;
        end
      end
    end
    drain();
  endtask

  // Receiver pacing: stall at the requested rate.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted output request with the oldest one owed.
  always @(posedge clk_i) begin : check_results
    decoded_t got;
    decoded_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind               = kind_e'(m_axis_tuser);
      got.class_index        = m_axis_tdata[12:0];
      got.symbol_score       = m_axis_tdata[28:13];
      got.average_confidence = m_axis_tdata[44:29];
      got.symbol_count       = m_axis_tdata[53:45];
      got.seq_end            = m_axis_tlast;
      if (decoded_q.size() == 0) begin
        if (mismatches < 10)
          $display({"[%0t] unexpected request: kind %0d class %0d score %0d",
                    " avg %0d count %0d last %0d"},
                   $realtime, got.kind, got.class_index, got.symbol_score,
                   got.average_confidence, got.symbol_count, got.seq_end);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        if (got !== want) begin
          if (mismatches < 10) begin
            $display("[%0t] request mismatch", $realtime);
            $display("  expected: kind %0d class %0d score %0d avg %0d count %0d last %0d",
                     want.kind, want.class_index, want.symbol_score,
                     want.average_confidence, want.symbol_count, want.seq_end);
            $display("  actual:   kind %0d class %0d score %0d avg %0d count %0d last %0d",
                     got.kind, got.class_index, got.symbol_score,
                     got.average_confidence, got.symbol_count, got.seq_end);
          end
          mismatches++;
        end
        if (want.kind == KIND_SUMMARY) summaries_seen++;
        else symbols_seen++;
      end
    end
  end

  // Watchdog: end the run when neither side has moved for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no request moved for %0d cycles, %0d still owed",
               QUIET_LIMIT, decoded_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    // Hold reset, then release it on an edge.
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_symbol_limit();
    test_random(0, 0, 170);
    test_random(77, 0, 170);
    test_random(0, 77, 170);
    test_random(20, 20, 170);

    // Anything still owed counts against the run.
    mismatches += decoded_q.size();
    $display("Sent %0d scores in %0d sequences; checked %0d symbols and %0d summaries.",
             scores_sent, seqs_sent, symbols_seen, summaries_seen);
    $display("Covered ties, blank and repeat drops, symbol count saturation, four pacings.");
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
